[hw/rtl/nrmc_pkg.sv]
// ----------------------------------------------------------------------------
// NMEA RMC parser package
// Shared types, character codes and helpers for the RMC sentence parser.
// ----------------------------------------------------------------------------
package nrmc_pkg;

    localparam int TIME_CHARS_DEF = 10;
    localparam int POS_CHARS_DEF  = 15;
    localparam int DATE_CHARS_DEF = 10;

    // widths of field lengths (up to 16) and character indexes
    localparam int LEN_W = 5;
    localparam int IDX_W = 4;

    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_R      = 8'h52;
    localparam logic [7:0] CH_M      = 8'h4D;
    localparam logic [7:0] CH_C      = 8'h43;

    // byte positions of the sentence type letters; '$' is position 0
    localparam logic [2:0] POS_R       = 3'd3;
    localparam logic [2:0] POS_M       = 3'd4;
    localparam logic [2:0] POS_C       = 3'd5;
    localparam logic [2:0] POS_TYPE_END = 3'd6;
    localparam logic [2:0] POS_SAT     = 3'd7;

    // comma counts that select a field
    localparam logic [3:0] CC_TIME    = 4'd1;
    localparam logic [3:0] CC_STATUS  = 4'd2;
    localparam logic [3:0] CC_LAT     = 4'd3;
    localparam logic [3:0] CC_LAT_DIR = 4'd4;
    localparam logic [3:0] CC_LON     = 4'd5;
    localparam logic [3:0] CC_LON_DIR = 4'd6;
    localparam logic [3:0] CC_DATE    = 4'd9;
    localparam logic [3:0] CC_SAT     = 4'd15;

    typedef enum logic [2:0] {
        FC_TIME,
        FC_STATUS,
        FC_LAT,
        FC_LAT_DIR,
        FC_LON,
        FC_LON_DIR,
        FC_DATE,
        FC_END
    } fcode_t;

    typedef enum logic [1:0] {
        STS_VALID,
        STS_CHECKSUM,
        STS_NOT_RMC,
        STS_NO_STAR
    } sstatus_t;

    typedef enum logic [2:0] {
        CS_IDLE,
        CS_BODY,
        CS_HEX1,
        CS_HEX2,
        CS_EMIT
    } ctrl_state_t;

    typedef struct packed {
        logic     open;       // '$' starts a sentence
        logic     body;       // body byte (not star, not line end)
        logic     star;       // star closes the body
        logic     hex1;       // first checksum digit
        logic     err_load;   // load a single status item
        sstatus_t err_status;
        logic     emit_start;
        logic     emit_step;
    } dp_cmd_t;

    typedef struct packed {
        logic is_dollar;
        logic is_eol;
        logic is_star;
        logic sum_ok;
        logic type_ok;
        logic slot_free;
        logic emit_end;
    } dp_sts_t;

    // bit 4 set flags a non-hex character
    function automatic logic [4:0] hex_value(input logic [7:0] c);
        logic [4:0] v;
        if (c >= 8'h30 && c <= 8'h39)
            v = {1'b0, 4'(c - 8'h30)};
        else if (c >= 8'h41 && c <= 8'h46)
            v = {1'b0, 4'(c - 8'h37)};
        else if (c >= 8'h61 && c <= 8'h66)
            v = {1'b0, 4'(c - 8'h57)};
        else
            v = 5'h10;
        return v;
    endfunction

endpackage

[hw/rtl/nmea_rmc_sentence_parser.sv]
// ----------------------------------------------------------------------------
// NMEA RMC sentence parser
// Parses an NMEA 0183 byte stream and reports the fields of valid RMC
// sentences, or one status item for a sentence that fails.
// ----------------------------------------------------------------------------
// One byte is taken per cycle. Inside a sentence body and on the second
// checksum digit a byte is taken only once the output register is free, since
// a line end or the last digit loads a result. After the second checksum digit
// of a valid RMC sentence the result sequencer reads the field stores one entry
// per cycle while the output register is free. It emits each captured character
// and the three direction/status items, takes an idle step for each empty
// multi-character field and ends with the end item. No byte is taken until
// the end item is loaded. Failed sentences give a single status item. Overlong
// fields keep their first TIME_CHARS, POS_CHARS or DATE_CHARS characters. There
// is no clearing pass after reset.
module nmea_rmc_sentence_parser #(
    parameter int TIME_CHARS = nrmc_pkg::TIME_CHARS_DEF,
    parameter int POS_CHARS  = nrmc_pkg::POS_CHARS_DEF,
    parameter int DATE_CHARS = nrmc_pkg::DATE_CHARS_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [7:0]                 rx_byte,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic [1:0]                 status,
    output logic [2:0]                 field_code,
    output logic [nrmc_pkg::IDX_W-1:0] char_index,
    output logic [7:0]                 char_value,
    output logic                       last
);
    import nrmc_pkg::*;

    dp_cmd_t cmd;
    dp_sts_t sts;

    nrmc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    nrmc_dp #(
        .TIME_CHARS (TIME_CHARS),
        .POS_CHARS  (POS_CHARS),
        .DATE_CHARS (DATE_CHARS)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .sts        (sts),
        .rx_byte    (rx_byte),
        .out_ready  (out_ready),
        .out_valid  (out_valid),
        .status     (status),
        .field_code (field_code),
        .char_index (char_index),
        .char_value (char_value),
        .last       (last)
    );

endmodule

[hw/rtl/nrmc_fstore.sv]
// ----------------------------------------------------------------------------
// NMEA RMC field store
// Character store for one multi-character field with a saturating length.
// ----------------------------------------------------------------------------
module nrmc_fstore #(
    parameter int DEPTH = nrmc_pkg::POS_CHARS_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       clear,
    input  logic                       wr_en,
    input  logic [7:0]                 wr_data,
    input  logic [nrmc_pkg::IDX_W-1:0] rd_idx,
    output logic [nrmc_pkg::LEN_W-1:0] len,
    output logic [7:0]                 rd_data
);
    import nrmc_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int LW = $clog2(DEPTH + 1);

    logic [7:0]    mem_reg [DEPTH];
    logic [7:0]    rd_data_reg;
    logic [LW-1:0] cnt_reg;
    logic [LW-1:0] cnt_next;
    logic          room;

    assign room = cnt_reg < LW'(DEPTH);

    always_comb
    begin
        cnt_next = cnt_reg;
        if (clear)
            cnt_next = '0;
        else if (wr_en && room)
            cnt_next = cnt_reg + LW'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= '0;
        else
            cnt_reg <= cnt_next;
    end

    // registered read: rd_data shows the entry at rd_idx in the cycle after
    always_ff @(posedge clk)
    begin
        if (!clear && wr_en && room)
            mem_reg[cnt_reg[AW-1:0]] <= wr_data;
        rd_data_reg <= mem_reg[rd_idx[AW-1:0]];
    end

    assign rd_data = rd_data_reg;
    assign len     = LEN_W'(cnt_reg);

endmodule

[hw/rtl/nrmc_ctrl.sv]
// ----------------------------------------------------------------------------
// NMEA RMC controller
// Sentence phase state machine; steers the datapath and the result burst.
// ----------------------------------------------------------------------------
module nrmc_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  nrmc_pkg::dp_sts_t sts,
    output nrmc_pkg::dp_cmd_t cmd
);
    import nrmc_pkg::*;

    ctrl_state_t state_reg;
    ctrl_state_t state_next;
    logic        take;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= CS_IDLE;
        else
            state_reg <= state_next;
    end

    assign take = in_valid && in_ready;

    always_comb
    begin
        state_next     = state_reg;
        in_ready       = 1'b0;
        cmd            = '0;
        cmd.err_status = STS_VALID;
        case (state_reg)
            CS_IDLE:
            begin
                in_ready = 1'b1;
                if (take && sts.is_dollar)
                begin
                    cmd.open   = 1'b1;
                    state_next = CS_BODY;
                end
            end
            CS_BODY:
            begin
                in_ready = sts.slot_free;
                if (take)
                begin
                    if (sts.is_eol)
                    begin
                        cmd.err_load   = 1'b1;
                        cmd.err_status = STS_NO_STAR;
                        state_next     = CS_IDLE;
                    end
                    else if (sts.is_star)
                    begin
                        cmd.star   = 1'b1;
                        state_next = CS_HEX1;
                    end
                    else
                        cmd.body = 1'b1;
                end
            end
            CS_HEX1:
            begin
                in_ready = 1'b1;
                if (take)
                begin
                    cmd.hex1   = 1'b1;
                    state_next = CS_HEX2;
                end
            end
            CS_HEX2:
            begin
                in_ready = sts.slot_free;
                if (take)
                begin
                    // checksum mismatch wins over wrong type
                    if (!sts.sum_ok)
                    begin
                        cmd.err_load   = 1'b1;
                        cmd.err_status = STS_CHECKSUM;
                        state_next     = CS_IDLE;
                    end
                    else if (!sts.type_ok)
                    begin
                        cmd.err_load   = 1'b1;
                        cmd.err_status = STS_NOT_RMC;
                        state_next     = CS_IDLE;
                    end
                    else
                    begin
                        cmd.emit_start = 1'b1;
                        state_next     = CS_EMIT;
                    end
                end
            end
            CS_EMIT:
            begin
                if (sts.slot_free)
                begin
                    cmd.emit_step = 1'b1;
                    if (sts.emit_end)
                        state_next = CS_IDLE;
                end
            end
            default:
                state_next = CS_IDLE;
        endcase
    end

endmodule

[hw/rtl/nrmc_dp.sv]
// ----------------------------------------------------------------------------
// NMEA RMC datapath
// Checksum, position and comma tracking, field capture, result sequencing
// and the output register.
// ----------------------------------------------------------------------------
module nrmc_dp #(
    parameter int TIME_CHARS = nrmc_pkg::TIME_CHARS_DEF,
    parameter int POS_CHARS  = nrmc_pkg::POS_CHARS_DEF,
    parameter int DATE_CHARS = nrmc_pkg::DATE_CHARS_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  nrmc_pkg::dp_cmd_t          cmd,
    output nrmc_pkg::dp_sts_t          sts,
    input  logic [7:0]                 rx_byte,
    input  logic                       out_ready,
    output logic                       out_valid,
    output logic [1:0]                 status,
    output logic [2:0]                 field_code,
    output logic [nrmc_pkg::IDX_W-1:0] char_index,
    output logic [7:0]                 char_value,
    output logic                       last
);
    import nrmc_pkg::*;

    // parse state
    logic [7:0] xor_reg,   xor_next;
    logic [2:0] pos_reg,   pos_next;
    logic [3:0] comma_reg, comma_next;
    logic       type_reg,  type_next;
    logic [4:0] hi_reg,    hi_next;
    logic [7:0] stat_ch_reg, stat_ch_next;
    logic [7:0] latd_reg,  latd_next;
    logic [7:0] lond_reg,  lond_next;

    // result sequencer
    fcode_t           code_reg, code_next;
    logic [IDX_W-1:0] idx_reg,  idx_next;

    // output register
    logic             oval_reg, oval_next;
    sstatus_t         ost_reg;
    fcode_t           ocode_reg;
    logic [IDX_W-1:0] oidx_reg;
    logic [7:0]       ochar_reg;
    logic             olast_reg;

    logic [2:0]       pos_inc;
    logic             is_comma;
    logic             cap;
    logic [4:0]       lo_nib;
    logic [LEN_W-1:0] len_time, len_lat, len_lon, len_date, sel_len;
    logic [7:0]       rd_time, rd_lat, rd_lon, rd_date, sel_data, sel_single;
    logic             idx_last;
    logic             emit_load;
    logic             emit_last;
    logic [7:0]       emit_val;
    logic             slot_free;

    assign is_comma = rx_byte == CH_COMMA;
    assign pos_inc  = (pos_reg == POS_SAT) ? pos_reg : pos_reg + 3'd1;
    assign cap      = cmd.body && !is_comma;
    assign lo_nib   = hex_value(rx_byte);

    assign slot_free     = !oval_reg || out_ready;
    assign sts.is_dollar = rx_byte == CH_DOLLAR;
    assign sts.is_eol    = (rx_byte == CH_CR) || (rx_byte == CH_LF);
    assign sts.is_star   = rx_byte == CH_STAR;
    assign sts.sum_ok    = !hi_reg[4] && !lo_nib[4] && ({hi_reg[3:0], lo_nib[3:0]} == xor_reg);
    assign sts.type_ok   = type_reg;
    assign sts.slot_free = slot_free;
    assign sts.emit_end  = code_reg == FC_END;

    // stores are addressed with the next index so their data lines up with idx_reg
    nrmc_fstore #(.DEPTH(TIME_CHARS)) u_time (
        .clk(clk), .rst_n(rst_n), .clear(cmd.open),
        .wr_en(cap && comma_reg == CC_TIME), .wr_data(rx_byte),
        .rd_idx(idx_next), .len(len_time), .rd_data(rd_time)
    );

    nrmc_fstore #(.DEPTH(POS_CHARS)) u_lat (
        .clk(clk), .rst_n(rst_n), .clear(cmd.open),
        .wr_en(cap && comma_reg == CC_LAT), .wr_data(rx_byte),
        .rd_idx(idx_next), .len(len_lat), .rd_data(rd_lat)
    );

    nrmc_fstore #(.DEPTH(POS_CHARS)) u_lon (
        .clk(clk), .rst_n(rst_n), .clear(cmd.open),
        .wr_en(cap && comma_reg == CC_LON), .wr_data(rx_byte),
        .rd_idx(idx_next), .len(len_lon), .rd_data(rd_lon)
    );

    nrmc_fstore #(.DEPTH(DATE_CHARS)) u_date (
        .clk(clk), .rst_n(rst_n), .clear(cmd.open),
        .wr_en(cap && comma_reg == CC_DATE), .wr_data(rx_byte),
        .rd_idx(idx_next), .len(len_date), .rd_data(rd_date)
    );

    // parse state update
    always_comb
    begin
        xor_next     = xor_reg;
        pos_next     = pos_reg;
        comma_next   = comma_reg;
        type_next    = type_reg;
        hi_next      = hi_reg;
        stat_ch_next = stat_ch_reg;
        latd_next    = latd_reg;
        lond_next    = lond_reg;
        if (cmd.open)
        begin
            xor_next   = '0;
            pos_next   = '0;
            comma_next = '0;
            type_next  = 1'b1;
            hi_next    = '0;
        end
        else if (cmd.star)
        begin
            pos_next = pos_inc;
            if (pos_inc < POS_TYPE_END)
                type_next = 1'b0;
        end
        else if (cmd.hex1)
            hi_next = lo_nib;
        else if (cmd.body)
        begin
            pos_next = pos_inc;
            if (!sts.is_dollar)
                xor_next = xor_reg ^ rx_byte;
            if ((pos_inc == POS_R && rx_byte != CH_R) ||
                (pos_inc == POS_M && rx_byte != CH_M) ||
                (pos_inc == POS_C && rx_byte != CH_C))
                type_next = 1'b0;
            if (is_comma)
            begin
                if (comma_reg != CC_SAT)
                    comma_next = comma_reg + 4'd1;
            end
            else
            begin
                case (comma_reg)
                    CC_STATUS:  stat_ch_next = rx_byte;
                    CC_LAT_DIR: latd_next    = rx_byte;
                    CC_LON_DIR: lond_next    = rx_byte;
                    default:    ;
                endcase
            end
        end
    end

    // result sequencer: walks the fields, one store entry per step
    always_comb
    begin
        sel_len    = '0;
        sel_data   = '0;
        sel_single = '0;
        case (code_reg)
            FC_TIME:    begin sel_len = len_time; sel_data = rd_time; end
            FC_LAT:     begin sel_len = len_lat;  sel_data = rd_lat;  end
            FC_LON:     begin sel_len = len_lon;  sel_data = rd_lon;  end
            FC_DATE:    begin sel_len = len_date; sel_data = rd_date; end
            FC_STATUS:  sel_single = stat_ch_reg;
            FC_LAT_DIR: sel_single = latd_reg;
            FC_LON_DIR: sel_single = lond_reg;
            default:    ;
        endcase
    end

    assign idx_last = ({1'b0, idx_reg} + LEN_W'(1)) == sel_len;

    always_comb
    begin
        code_next = code_reg;
        idx_next  = idx_reg;
        emit_load = 1'b0;
        emit_last = 1'b0;
        emit_val  = '0;
        if (cmd.emit_start)
        begin
            code_next = FC_TIME;
            idx_next  = '0;
        end
        else if (cmd.emit_step)
        begin
            case (code_reg)
                FC_TIME, FC_LAT, FC_LON, FC_DATE:
                begin
                    // an empty field costs one idle step
                    if (sel_len == '0)
                        code_next = fcode_t'(code_reg + 3'd1);
                    else
                    begin
                        emit_load = 1'b1;
                        emit_val  = sel_data;
                        if (idx_last)
                        begin
                            code_next = fcode_t'(code_reg + 3'd1);
                            idx_next  = '0;
                        end
                        else
                            idx_next = idx_reg + IDX_W'(1);
                    end
                end
                FC_STATUS, FC_LAT_DIR, FC_LON_DIR:
                begin
                    emit_load = 1'b1;
                    emit_val  = sel_single;
                    code_next = fcode_t'(code_reg + 3'd1);
                end
                FC_END:
                begin
                    emit_load = 1'b1;
                    emit_last = 1'b1;
                end
                default: ;
            endcase
        end
    end

    always_comb
    begin
        oval_next = oval_reg;
        if (cmd.err_load || emit_load)
            oval_next = 1'b1;
        else if (out_ready)
            oval_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            xor_reg     <= '0;
            pos_reg     <= '0;
            comma_reg   <= '0;
            type_reg    <= 1'b1;
            hi_reg      <= '0;
            stat_ch_reg <= '0;
            latd_reg    <= '0;
            lond_reg    <= '0;
            code_reg    <= FC_TIME;
            idx_reg     <= '0;
            oval_reg    <= 1'b0;
        end
        else
        begin
            xor_reg     <= xor_next;
            pos_reg     <= pos_next;
            comma_reg   <= comma_next;
            type_reg    <= type_next;
            hi_reg      <= hi_next;
            stat_ch_reg <= stat_ch_next;
            latd_reg    <= latd_next;
            lond_reg    <= lond_next;
            code_reg    <= code_next;
            idx_reg     <= idx_next;
            oval_reg    <= oval_next;
        end
    end

    // payload of the output register
    always_ff @(posedge clk)
    begin
        if (cmd.err_load)
        begin
            ost_reg   <= cmd.err_status;
            ocode_reg <= FC_END;
            oidx_reg  <= '0;
            ochar_reg <= '0;
            olast_reg <= 1'b1;
        end
        else if (emit_load)
        begin
            ost_reg   <= STS_VALID;
            ocode_reg <= code_reg;
            oidx_reg  <= (code_reg == FC_END) ? '0 : idx_reg;
            ochar_reg <= emit_val;
            olast_reg <= emit_last;
        end
    end

    assign out_valid  = oval_reg;
    assign status     = ost_reg;
    assign field_code = ocode_reg;
    assign char_index = oidx_reg;
    assign char_value = ochar_reg;
    assign last       = olast_reg;

endmodule
